>>> design/agd_pkg.sv
// agd_pkg: widths, register codes, reset values and shared types of the
// audio glitch detector. Used by the interfaces, agd_channel and the top level.
// No dependencies.
package agd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = 35;
  localparam int MAG_W       = 34;
  localparam int POS_W       = 11;
  localparam int TOTAL_W     = 32;
  localparam int CNT_W       = 11;
  localparam int LIMIT_W     = 23;
  localparam int ADC_W       = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int NUM_SLOTS   = 8;

  localparam int MAX_FRAMES_DEF  = 1024;
  localparam int SKIP_FRAMES_DEF = 10;

  localparam logic [LIMIT_W-1:0]  STEP_MIN            = 23'd838860;
  localparam logic [LIMIT_W-1:0]  STEP_THRESHOLD_RST  = 23'd4194303;
  localparam logic [LIMIT_W-1:0]  DC_LIMIT_RST        = 23'd5872024;
  localparam logic [LIMIT_W-1:0]  OVERLOAD_LIMIT_RST  = 23'd7969176;
  localparam logic [SAMPLE_W-1:0] DROPOUT_LIMIT_RST   = 24'd419431;

  localparam logic [MAG_W-1:0]        MAG_MAX = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_STEP     = 3'd1,
    REG_DC       = 3'd2,
    REG_OVERLOAD = 3'd3,
    REG_DROPOUT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_STEP     = 2'd0,
    KIND_DC       = 2'd1,
    KIND_OVERLOAD = 2'd2,
    KIND_DROPOUT  = 2'd3
  } glitch_kind_t;

  // event slots of one frame, in delivery order
  typedef enum logic [2:0] {
    EV_STEP_L = 3'd0,
    EV_STEP_R = 3'd1,
    EV_DC_L   = 3'd2,
    EV_OVL_L  = 3'd3,
    EV_DRP_L  = 3'd4,
    EV_DC_R   = 3'd5,
    EV_OVL_R  = 3'd6,
    EV_DRP_R  = 3'd7
  } ev_slot_t;

  // per-channel statistics after the current frame
  typedef struct packed {
    logic                       disc;
    logic [SAMPLE_W-1:0]        step_mag;
    logic signed [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0]        peak;
    logic [CNT_W-1:0]           count;
  } agd_chan_res_t;

endpackage

>>> design/agd_if.sv
// agd_if: valid/ready channel interfaces of the audio glitch detector,
// one for stereo frames and one for glitch events. Depends on agd_pkg.
interface agd_frame_if import agd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [ADC_W-1:0]           adc_index;
  logic                       last_frame;

  modport source (output valid, left_sample, right_sample, adc_index, last_frame,
                  input ready);
  modport sink (input valid, left_sample, right_sample, adc_index, last_frame,
                output ready);
endinterface

interface agd_event_if import agd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         glitch_kind;
  logic               channel;
  logic [ADC_W-1:0]   source_adc;
  logic [MAG_W-1:0]   magnitude;
  logic [POS_W-1:0]   frame_position;
  logic [TOTAL_W-1:0] glitch_total;
  logic               last_of_run;

  modport source (output valid, glitch_kind, channel, source_adc, magnitude,
                  frame_position, glitch_total, last_of_run,
                  input ready);
  modport sink (input valid, glitch_kind, channel, source_adc, magnitude,
                frame_position, glitch_total, last_of_run,
                output ready);
endinterface

>>> design/audio_glitch_detector_top.sv
// audio_glitch_detector_top: glitch checker for buffers of stereo 24-bit
// frames. Depends on agd_pkg, agd_frame_if, agd_event_if and agd_channel.
//
// Usage
//   frame  : valid/ready sink of stereo frames; last_frame marks the end of
//            a buffer. With enable_flag low, frames are taken and dropped.
//   glitch : valid/ready source of events. A frame yields up to eight
//            events (left step, right step, then on the last frame left DC,
//            overload, dropout and right DC, overload, dropout);
//            last_of_run marks the final event of a frame.
//   cfg_*  : write-only register port; the user must see that it is written
//            only while the block is idle; the block itself does not enforce it.
// Path: frame register, event stage, output register. Throughput: one frame
//   per cycle while frames cause at most one event and glitch.ready is high;
//   a frame with more events holds the event stage until the output register,
//   which takes one event per cycle while glitch.ready is high, has sent them.
// Reset: clears registers to their defaults, all buffer statistics, the
//   frame index and the glitch total; nothing is in flight afterwards.
// Stall: a stalled glitch beat holds in the output register; the event
//   stage and then the frame register fill, after which frame.ready drops.
module audio_glitch_detector_top
  import agd_pkg::*;
#(
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  parameter int SKIP_FRAMES = SKIP_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  agd_frame_if.sink              frame,
  agd_event_if.source            glitch
);

  localparam int FW = $clog2(MAX_FRAMES + 1);
  localparam int PW = LIMIT_W + FW;
  localparam int CW = ((PW > SUM_W) ? PW : SUM_W) + 1;

  // configuration registers
  logic                enable_flag;
  logic [LIMIT_W-1:0]  step_threshold;
  logic [LIMIT_W-1:0]  dc_limit;
  logic [LIMIT_W-1:0]  overload_limit;
  logic [SAMPLE_W-1:0] dropout_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_flag    <= 1'b0;
      step_threshold <= STEP_THRESHOLD_RST;
      dc_limit       <= DC_LIMIT_RST;
      overload_limit <= OVERLOAD_LIMIT_RST;
      dropout_limit  <= DROPOUT_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE: begin
          enable_flag <= cfg_data[0];
        end
        REG_STEP: begin
          step_threshold <= (cfg_data[LIMIT_W-1:0] < STEP_MIN) ? STEP_MIN
                                                               : cfg_data[LIMIT_W-1:0];
        end
        REG_DC: begin
          dc_limit <= cfg_data[LIMIT_W-1:0];
        end
        REG_OVERLOAD: begin
          overload_limit <= cfg_data[LIMIT_W-1:0];
        end
        REG_DROPOUT: begin
          dropout_limit <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // handshake between stages
  logic s1_valid;
  logic s2_valid;
  logic o_valid;
  logic out_free;
  logic out_load;
  logic s2_done;
  logic s2_free;
  logic s1_fire;
  logic frame_take;

  logic [NUM_SLOTS-1:0] flags;
  logic [NUM_SLOTS-1:0] sent;
  logic [NUM_SLOTS-1:0] pending;
  logic [NUM_SLOTS-1:0] pick;
  logic                 pick_any;
  logic                 pick_last;
  ev_slot_t             pick_idx;

  assign out_free   = !o_valid || glitch.ready;
  assign pending    = s2_valid ? (flags & ~sent) : '0;
  assign pick       = pending & (~pending + 1'b1);
  assign pick_any   = |pending;
  assign pick_last  = (pending & ~pick) == '0;
  assign out_load   = pick_any && out_free;
  assign s2_done    = s2_valid && (!pick_any || (out_load && pick_last));
  assign s2_free    = !s2_valid || s2_done;
  assign s1_fire    = s1_valid && s2_free;
  assign frame.ready = !s1_valid || s2_free;
  assign frame_take = frame.valid && frame.ready && enable_flag;

  // frame register
  logic signed [SAMPLE_W-1:0] s1_left;
  logic signed [SAMPLE_W-1:0] s1_right;
  logic [ADC_W-1:0]           s1_adc;
  logic                       s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame_take;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      s1_left  <= frame.left_sample;
      s1_right <= frame.right_sample;
      s1_adc   <= frame.adc_index;
      s1_last  <= frame.last_frame;
    end
  end

  // frame index and buffer statistics
  logic [FW-1:0]  frame_index;
  logic [FW-1:0]  n;
  logic [PW-1:0]  prod;
  agd_chan_res_t  chan_res [2];

  assign n    = (frame_index == FW'(MAX_FRAMES)) ? frame_index : frame_index + 1'b1;
  assign prod = PW'(dc_limit) * PW'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
    end else if (s1_fire) begin
      frame_index <= s1_last ? '0 : n;
    end
  end

  agd_channel #(
    .FW          (FW),
    .SKIP_FRAMES (SKIP_FRAMES)
  ) u_left (
    .clk            (clk),
    .rst            (rst),
    .sample         (s1_left),
    .frame_index    (frame_index),
    .update         (s1_fire),
    .clear          (s1_last),
    .step_threshold (step_threshold),
    .dropout_limit  (dropout_limit),
    .res            (chan_res[0])
  );

  agd_channel #(
    .FW          (FW),
    .SKIP_FRAMES (SKIP_FRAMES)
  ) u_right (
    .clk            (clk),
    .rst            (rst),
    .sample         (s1_right),
    .frame_index    (frame_index),
    .update         (s1_fire),
    .clear          (s1_last),
    .step_threshold (step_threshold),
    .dropout_limit  (dropout_limit),
    .res            (chan_res[1])
  );

  // event stage
  agd_chan_res_t    s2_chan [2];
  logic [FW-1:0]    s2_pos;
  logic [FW-1:0]    s2_n;
  logic [PW-1:0]    s2_prod;
  logic [ADC_W-1:0] s2_adc;
  logic             s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      sent     <= '0;
    end else begin
      if (s2_free) begin
        s2_valid <= s1_fire;
      end
      if (s1_fire) begin
        sent <= '0;
      end else if (out_load) begin
        sent <= sent | pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_chan[0] <= chan_res[0];
      s2_chan[1] <= chan_res[1];
      s2_pos     <= frame_index;
      s2_n       <= n;
      s2_prod    <= prod;
      s2_adc     <= s1_adc;
      s2_last    <= s1_last;
    end
  end

  logic [CW-1:0]          prod_ext;
  logic signed [CW-1:0]   sum_plus [2];
  logic [SUM_W-1:0]       abs_sum [2];
  logic [MAG_W-1:0]       mag_dc [2];
  logic                   dc_flag [2];
  logic                   ovl_flag [2];
  logic                   drp_flag [2];

  assign prod_ext = CW'(s2_prod);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      // |sum| > dc_limit * n, with |sum| clamped to the magnitude range
      sum_plus[c] = CW'($signed(s2_chan[c].sum)) + $signed(prod_ext);
      if (s2_chan[c].sum[SUM_W-1]) begin
        dc_flag[c] = sum_plus[c][CW-1] && (prod_ext < CW'(MAG_MAX));
      end else begin
        dc_flag[c] = CW'(s2_chan[c].sum[MAG_W-1:0]) > prod_ext;
      end
      abs_sum[c]  = s2_chan[c].sum[SUM_W-1] ? (~s2_chan[c].sum + 1'b1) : s2_chan[c].sum;
      mag_dc[c]   = abs_sum[c][SUM_W-1] ? MAG_MAX : abs_sum[c][MAG_W-1:0];
      ovl_flag[c] = s2_chan[c].peak > {1'b0, overload_limit};
      drp_flag[c] = 32'(s2_chan[c].count) > 32'(s2_n >> 1);
    end

    flags            = '0;
    flags[EV_STEP_L] = s2_chan[0].disc;
    flags[EV_STEP_R] = s2_chan[1].disc;
    flags[EV_DC_L]   = s2_last && dc_flag[0];
    flags[EV_OVL_L]  = s2_last && ovl_flag[0];
    flags[EV_DRP_L]  = s2_last && drp_flag[0];
    flags[EV_DC_R]   = s2_last && dc_flag[1];
    flags[EV_OVL_R]  = s2_last && ovl_flag[1];
    flags[EV_DRP_R]  = s2_last && drp_flag[1];
  end

  always_comb begin
    pick_idx = EV_STEP_L;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (pending[k]) begin
        pick_idx = ev_slot_t'(k);
      end
    end
  end

  glitch_kind_t     ev_kind;
  logic             ev_chan;
  logic [MAG_W-1:0] ev_mag;
  logic [POS_W-1:0] ev_pos;

  always_comb begin
    ev_pos = POS_W'(s2_n);
    case (pick_idx)
      EV_STEP_L: begin
        ev_kind = KIND_STEP;
        ev_chan = 1'b0;
        ev_mag  = MAG_W'(s2_chan[0].step_mag);
        ev_pos  = POS_W'(s2_pos);
      end
      EV_STEP_R: begin
        ev_kind = KIND_STEP;
        ev_chan = 1'b1;
        ev_mag  = MAG_W'(s2_chan[1].step_mag);
        ev_pos  = POS_W'(s2_pos);
      end
      EV_DC_L: begin
        ev_kind = KIND_DC;
        ev_chan = 1'b0;
        ev_mag  = mag_dc[0];
      end
      EV_OVL_L: begin
        ev_kind = KIND_OVERLOAD;
        ev_chan = 1'b0;
        ev_mag  = MAG_W'(s2_chan[0].peak);
      end
      EV_DRP_L: begin
        ev_kind = KIND_DROPOUT;
        ev_chan = 1'b0;
        ev_mag  = MAG_W'(s2_chan[0].count);
      end
      EV_DC_R: begin
        ev_kind = KIND_DC;
        ev_chan = 1'b1;
        ev_mag  = mag_dc[1];
      end
      EV_OVL_R: begin
        ev_kind = KIND_OVERLOAD;
        ev_chan = 1'b1;
        ev_mag  = MAG_W'(s2_chan[1].peak);
      end
      EV_DRP_R: begin
        ev_kind = KIND_DROPOUT;
        ev_chan = 1'b1;
        ev_mag  = MAG_W'(s2_chan[1].count);
      end
      default: begin
        ev_kind = KIND_STEP;
        ev_chan = 1'b0;
        ev_mag  = '0;
      end
    endcase
  end

  // output register and glitch total
  logic [TOTAL_W-1:0] total;
  glitch_kind_t       o_kind;
  logic               o_chan;
  logic [ADC_W-1:0]   o_adc;
  logic [MAG_W-1:0]   o_mag;
  logic [POS_W-1:0]   o_pos;
  logic [TOTAL_W-1:0] o_total;
  logic               o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      total   <= '0;
    end else if (out_load) begin
      o_valid <= 1'b1;
      total   <= total + 1'b1;
    end else if (glitch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind  <= ev_kind;
      o_chan  <= ev_chan;
      o_adc   <= s2_adc;
      o_mag   <= ev_mag;
      o_pos   <= ev_pos;
      o_total <= total + 1'b1;
      o_last  <= pick_last;
    end
  end

  assign glitch.valid          = o_valid;
  assign glitch.glitch_kind    = o_kind;
  assign glitch.channel        = o_chan;
  assign glitch.source_adc     = o_adc;
  assign glitch.magnitude      = o_mag;
  assign glitch.frame_position = o_pos;
  assign glitch.glitch_total   = o_total;
  assign glitch.last_of_run    = o_last;

  // each loaded event bumps the total by exactly one
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> total == $past(total) + 1'b1)
    else $error("glitch total did not advance with an event");

  // only events that were raised can have been sent
  a_sent_subset: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (sent & ~flags) == '0)
    else $error("sent mask holds an event that was never raised");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    frame_index <= FW'(MAX_FRAMES))
    else $error("frame index beyond its limit");

  // the end of a buffer restarts the frame count
  a_buffer_end: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> frame_index == '0)
    else $error("frame index not cleared at end of buffer");

endmodule

>>> design/agd_channel.sv
// agd_channel: per-channel buffer statistics (previous sample, running sum,
// peak, near-zero count) and the step check for one frame. Depends on agd_pkg.
module agd_channel
  import agd_pkg::*;
#(
  parameter int FW          = 11,
  parameter int SKIP_FRAMES = SKIP_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [FW-1:0]              frame_index,
  input  logic                       update,
  input  logic                       clear,
  input  logic [LIMIT_W-1:0]         step_threshold,
  input  logic [SAMPLE_W-1:0]        dropout_limit,
  output agd_chan_res_t              res
);

  localparam int SX  = SAMPLE_W + 1;
  localparam int SW1 = SUM_W + 1;

  logic signed [SAMPLE_W-1:0] prev;
  logic signed [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0]        peak;
  logic [CNT_W-1:0]           count;

  logic signed [SX-1:0]    v_ext;
  logic signed [SX-1:0]    abs_wide;
  logic signed [SX-1:0]    diff;
  logic signed [SX-1:0]    abs_diff;
  logic [SAMPLE_W-1:0]     mag;
  logic signed [SW1-1:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic [SAMPLE_W-1:0]     peak_next;
  logic [CNT_W-1:0]        count_next;
  logic                    near_zero;

  always_comb begin
    v_ext    = SX'(sample);
    abs_wide = v_ext[SAMPLE_W] ? -v_ext : v_ext;
    mag      = abs_wide[SAMPLE_W-1:0];
    diff     = SX'(sample) - SX'(prev);
    abs_diff = diff[SAMPLE_W] ? -diff : diff;

    peak_next = (mag > peak) ? mag : peak;

    // saturate the running sum to its 35-bit range
    sum_wide = SW1'(sum) + SW1'(sample);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end

    near_zero = (mag < dropout_limit) && (32'(frame_index) > 32'(SKIP_FRAMES)) &&
                (count != '1);
    count_next = near_zero ? count + 1'b1 : count;

    res.disc     = (frame_index != '0) &&
                   (abs_diff[SAMPLE_W-1:0] > {1'b0, step_threshold});
    res.step_mag = abs_diff[SAMPLE_W-1:0];
    res.sum      = sum_next;
    res.peak     = peak_next;
    res.count    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      sum   <= '0;
      peak  <= '0;
      count <= '0;
    end else if (update) begin
      if (clear) begin
        prev  <= '0;
        sum   <= '0;
        peak  <= '0;
        count <= '0;
      end else begin
        prev  <= sample;
        sum   <= sum_next;
        peak  <= peak_next;
        count <= count_next;
      end
    end
  end

endmodule

>>> tb/tb.sv
// tb: self-checking bench for audio_glitch_detector_top, with a built-in
// prediction of every glitch beat and random frame/event flow control.
// Depends on agd_pkg, agd_frame_if, agd_event_if and the detector RTL.
`timescale 1ns / 100ps

module tb;
  import agd_pkg::*;

  localparam int MAX_CYCLES    = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int LONG_FRAMES   = 48;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 28;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;

  typedef struct {
    glitch_kind_t        kind;
    logic                channel;
    logic [ADC_W-1:0]    adc;
    logic [MAG_W-1:0]    mag;
    logic [POS_W-1:0]    pos;
    logic [TOTAL_W-1:0]  total;
    logic                last_of_run;
  } glitch_event_t;

  typedef enum int {
    STY_QUIET,
    STY_LOUD,
    STY_BIASED,
    STY_WILD,
    STY_STEPPY
  } sample_style_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  agd_frame_if frame_ch ();
  agd_event_if glitch_ch ();

  audio_glitch_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_ch),
    .glitch    (glitch_ch)
  );

  // register copies and buffer statistics of the predictor
  logic                       cfg_enable;
  logic [LIMIT_W-1:0]         cfg_step;
  logic [LIMIT_W-1:0]         cfg_dc;
  logic [LIMIT_W-1:0]         cfg_overload;
  logic [SAMPLE_W-1:0]        cfg_dropout;
  logic signed [SAMPLE_W-1:0] prev_sample [2];
  logic signed [SUM_W-1:0]    sum_acc [2];
  logic [SAMPLE_W-1:0]        peak_mag [2];
  logic [CNT_W-1:0]           quiet_count [2];
  logic [POS_W-1:0]           frame_pos;
  logic [TOTAL_W-1:0]         glitch_count;

  glitch_event_t expected_glitches [$];

  int errors         = 0;
  int frames_sent    = 0;
  int glitches_seen  = 0;
  int reg_writes     = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("beat %0d %s got %0d expected %0d",
                           glitches_seen, name, got, want));
  endtask

  task automatic check_glitch();
    glitch_event_t want;
    if (expected_glitches.size() == 0) begin
      flag_error($sformatf("unexpected beat kind %0d channel %0d magnitude %0d",
                           glitch_ch.glitch_kind, glitch_ch.channel,
                           glitch_ch.magnitude));
      return;
    end
    want = expected_glitches.pop_front();
    check_field("glitch_kind", 64'(glitch_ch.glitch_kind), 64'(want.kind));
    check_field("channel", 64'(glitch_ch.channel), 64'(want.channel));
    check_field("source_adc", 64'(glitch_ch.source_adc), 64'(want.adc));
    check_field("magnitude", 64'(glitch_ch.magnitude), 64'(want.mag));
    check_field("frame_position", 64'(glitch_ch.frame_position), 64'(want.pos));
    check_field("glitch_total", 64'(glitch_ch.glitch_total), 64'(want.total));
    check_field("last_of_run", 64'(glitch_ch.last_of_run), 64'(want.last_of_run));
    glitches_seen++;
  endtask

  // sample the beat before the edge moves it, then pick the next ready
  always @(posedge clk) begin
    if (!rst && glitch_ch.valid && glitch_ch.ready)
      check_glitch();
    glitch_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic reset_model();
    cfg_enable   = 1'b0;
    cfg_step     = STEP_THRESHOLD_RST;
    cfg_dc       = DC_LIMIT_RST;
    cfg_overload = OVERLOAD_LIMIT_RST;
    cfg_dropout  = DROPOUT_LIMIT_RST;
    for (int ch = 0; ch < 2; ch++) begin
      prev_sample[ch] = '0;
      sum_acc[ch]     = '0;
      peak_mag[ch]    = '0;
      quiet_count[ch] = '0;
    end
    frame_pos    = '0;
    glitch_count = '0;
  endtask

  function automatic glitch_event_t make_glitch(input glitch_kind_t kind, input int ch,
                                                input logic [ADC_W-1:0] adc,
                                                input longint mag, input int pos);
    glitch_event_t ev;
    glitch_count   = glitch_count + 1;
    ev.kind        = kind;
    ev.channel     = ch[0];
    ev.adc         = adc;
    ev.mag         = mag[MAG_W-1:0];
    ev.pos         = pos[POS_W-1:0];
    ev.total       = glitch_count;
    ev.last_of_run = 1'b0;
    return ev;
  endfunction

  task automatic predict_frame(input logic signed [SAMPLE_W-1:0] left,
                               input logic signed [SAMPLE_W-1:0] right,
                               input logic [ADC_W-1:0] adc, input logic is_last);
    glitch_event_t evs [NUM_SLOTS];
    longint v, a, d, mag, s;
    int idx, n, k;
    if (!cfg_enable)
      return;
    k   = 0;
    idx = int'(frame_pos);
    for (int ch = 0; ch < 2; ch++) begin
      v = longint'((ch == 0) ? left : right);
      a = (v < 0) ? -v : v;
      if (a > peak_mag[ch])
        peak_mag[ch] = a[SAMPLE_W-1:0];
      s = sum_acc[ch] + v;
      if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
      if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
      sum_acc[ch] = s[SUM_W-1:0];
      // the first frame of a buffer has nothing to step from
      if (idx > 0) begin
        d   = v - prev_sample[ch];
        mag = (d < 0) ? -d : d;
        if (mag > longint'(cfg_step)) begin
          evs[k] = make_glitch(KIND_STEP, ch, adc, mag, idx);
          k++;
        end
      end
      if (a < longint'(cfg_dropout) && idx > SKIP_FRAMES_DEF && quiet_count[ch] != '1)
        quiet_count[ch]++;
      prev_sample[ch] = v[SAMPLE_W-1:0];
    end
    n = (idx + 1 > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : idx + 1;
    frame_pos = n[POS_W-1:0];
    if (is_last) begin
      for (int ch = 0; ch < 2; ch++) begin
        s   = sum_acc[ch];
        mag = (s < 0) ? -s : s;
        if (mag > longint'(MAG_MAX))
          mag = longint'(MAG_MAX);
        if (mag > longint'(cfg_dc) * n) begin
          evs[k] = make_glitch(KIND_DC, ch, adc, mag, n);
          k++;
        end
        if (peak_mag[ch] > cfg_overload) begin
          evs[k] = make_glitch(KIND_OVERLOAD, ch, adc, longint'(peak_mag[ch]), n);
          k++;
        end
        if (quiet_count[ch] > n / 2) begin
          evs[k] = make_glitch(KIND_DROPOUT, ch, adc, longint'(quiet_count[ch]), n);
          k++;
        end
        prev_sample[ch] = '0;
        sum_acc[ch]     = '0;
        peak_mag[ch]    = '0;
        quiet_count[ch] = '0;
      end
      frame_pos = '0;
    end
    if (k > 0)
      evs[k-1].last_of_run = 1'b1;
    for (int j = 0; j < k; j++)
      expected_glitches.push_back(evs[j]);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:   cfg_enable = value[0];
      REG_STEP:     cfg_step = (value[LIMIT_W-1:0] < STEP_MIN) ? STEP_MIN
                                                               : value[LIMIT_W-1:0];
      REG_DC:       cfg_dc = value[LIMIT_W-1:0];
      REG_OVERLOAD: cfg_overload = value[LIMIT_W-1:0];
      REG_DROPOUT:  cfg_dropout = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] dc,
                            input logic [CFG_DATA_W-1:0] ovl, input logic [CFG_DATA_W-1:0] drop);
    write_reg(REG_STEP, step);
    write_reg(REG_DC, dc);
    write_reg(REG_OVERLOAD, ovl);
    write_reg(REG_DROPOUT, drop);
  endtask

  task automatic set_default_limits();
    set_limits(CFG_DATA_W'(STEP_THRESHOLD_RST), CFG_DATA_W'(DC_LIMIT_RST),
               CFG_DATA_W'(OVERLOAD_LIMIT_RST), DROPOUT_LIMIT_RST);
  endtask

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right,
                            input logic [ADC_W-1:0] adc, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid        <= 1'b1;
    frame_ch.left_sample  <= left;
    frame_ch.right_sample <= right;
    frame_ch.adc_index    <= adc;
    frame_ch.last_frame   <= is_last;
    do @(posedge clk); while (!frame_ch.ready);
    predict_frame(left, right, adc, is_last);
    frames_sent++;
  endtask

  // drain all expected beats, then give frames with no events time to clear
  task automatic wait_idle();
    int waited;
    waited = 0;
    frame_ch.valid <= 1'b0;
    while (expected_glitches.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_glitches.size() != 0) begin
      flag_error($sformatf("%0d expected glitch beats never arrived",
                           expected_glitches.size()));
      expected_glitches.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample(input sample_style_t style,
      input int bias, input logic signed [SAMPLE_W-1:0] prior);
    int v;
    logic [31:0] raw;
    raw = $urandom();
    case (style)
      STY_QUIET:  v = int'($urandom_range(0, 1000000)) - 500000;
      STY_LOUD: begin
        v = int'($urandom_range(7500000, 8388608));
        if ($urandom_range(1) != 0)
          v = -v;
      end
      STY_BIASED: v = bias + int'($urandom_range(0, 200000)) - 100000;
      STY_WILD:   return raw[SAMPLE_W-1:0];
      STY_STEPPY: begin
        if ($urandom_range(5) == 0)
          return raw[SAMPLE_W-1:0];
        v = int'(prior) + int'($urandom_range(0, 400000)) - 200000;
      end
      default:    v = 0;
    endcase
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_random_buffer(output int count);
    sample_style_t style [2];
    int bias [2];
    logic signed [SAMPLE_W-1:0] smp [2];
    int len, roll;
    logic [ADC_W-1:0] adc;
    logic ragged, is_last;
    roll = $urandom_range(99);
    len = (roll < 70) ? $urandom_range(1, 24) :
          (roll < 95) ? $urandom_range(24, 48) : $urandom_range(60, 90);
    // a few buffers carry arbitrary end marks
    ragged = ($urandom_range(9) == 0);
    adc = ADC_W'($urandom());
    for (int ch = 0; ch < 2; ch++) begin
      style[ch] = sample_style_t'($urandom_range(4));
      bias[ch]  = int'($urandom_range(0, 16777215)) - 8388608;
      smp[ch]   = '0;
    end
    for (int f = 0; f < len; f++) begin
      for (int ch = 0; ch < 2; ch++)
        smp[ch] = next_sample(style[ch], bias[ch], smp[ch]);
      is_last = ragged ? ($urandom_range(3) == 0) : (f == len - 1);
      if ($urandom_range(7) == 0)
        adc = ADC_W'($urandom());
      send_frame(smp[0], smp[1], adc, is_last);
    end
    count = len;
  endtask

  task automatic test_enable_gating();
    logic [31:0] raw;
    set_traffic(0, 0);
    // still disabled from reset: frames are swallowed
    repeat (4) begin
      raw = $urandom();
      send_frame(raw[23:0], SAMPLE_W'($urandom()), raw[25:24], raw[26]);
    end
    wait_idle();
    write_reg(REG_ENABLE, 24'd1);
    send_frame(24'sh100000, -24'sh100000, 2'd1, 1'b0);
    // one above the default threshold on both channels
    send_frame(-24'sh300000, 24'sh300000, 2'd2, 1'b0);
    wait_idle();
    // only bit 0 of the enable data counts
    write_reg(REG_ENABLE, 24'hFFFFFE);
    repeat (5) begin
      raw = $urandom();
      send_frame(raw[23:0], SAMPLE_W'($urandom()), raw[25:24], raw[26]);
    end
    send_frame(FULL_POS, FULL_NEG, 2'd0, 1'b1);
    wait_idle();
    write_reg(REG_ENABLE, 24'h000001);
    send_frame(FULL_POS, FULL_NEG, 2'd3, 1'b0);
    send_frame(24'sd0, 24'sd0, 2'd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    set_traffic(0, 0);
    set_default_limits();
    // one-frame buffers: end-of-buffer checks with a frame count of one
    send_frame(FULL_POS, FULL_NEG, 2'd3, 1'b1);
    send_frame(24'sd7969176, -24'sd7969177, 2'd2, 1'b1);
    // full-scale swings, then a step equal to the threshold, then one above
    send_frame(FULL_NEG, FULL_POS, 2'd0, 1'b0);
    send_frame(FULL_POS, FULL_NEG, 2'd1, 1'b0);
    send_frame(24'sd0, 24'sd0, 2'd2, 1'b0);
    send_frame(24'sd4194303, -24'sd4194303, 2'd3, 1'b0);
    send_frame(24'sd0, 24'sd1, 2'd0, 1'b0);
    send_frame(24'sd0, 24'sd0, 2'd1, 1'b1);
    wait_idle();
    // zero limits, step threshold raised to its floor
    set_limits(24'd0, 24'd0, 24'd0, 24'd0);
    send_frame(24'sd838860, -24'sd838861, 2'd0, 1'b0);
    send_frame(24'sd0, 24'sd0, 2'd1, 1'b0);
    send_frame(24'sd1, 24'sd0, 2'd2, 1'b1);
    wait_idle();
    // all-ones data: upper bit dropped on the 23-bit registers
    set_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(FULL_NEG, FULL_POS, 2'd1, 1'b0);
    send_frame(FULL_POS, FULL_NEG, 2'd2, 1'b1);
    wait_idle();
  endtask

  // buffers past the skipped frames with a full-scale channel: large sums,
  // overload peaks and a quiet channel that counts as dropout
  task automatic test_long_buffers();
    logic signed [SAMPLE_W-1:0] left, right;
    logic [ADC_W-1:0] adc;
    set_traffic(0, 0);
    set_default_limits();
    for (int b = 0; b < 2; b++) begin
      adc  = ADC_W'($urandom());
      left = (b == 0) ? FULL_POS : FULL_NEG;
      for (int f = 0; f < LONG_FRAMES; f++) begin
        right = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
        if (b == 0 && f == LONG_FRAMES / 2)
          right = FULL_NEG;
        send_frame(left, right, adc, f == LONG_FRAMES - 1);
      end
      wait_idle();
    end
  endtask

  task automatic test_random_buffers();
    int sent, count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: set_traffic(0, 0);
        1: set_traffic(80, 0);
        2: set_traffic(0, 80);
        default: set_traffic(8, 8);
      endcase
      case (p)
        1: set_limits(24'd0, 24'd0, 24'd0, 24'd0);
        2: set_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        3: set_default_limits();
        5: set_limits(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom_range(0, 8388607)),
                      CFG_DATA_W'($urandom_range(7000000, 8388607)), 24'd8388608);
        default: set_limits(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom_range(0, 8388607)),
                            CFG_DATA_W'($urandom()),
                            ($urandom_range(1) != 0) ? CFG_DATA_W'($urandom_range(0, 1048576))
                                                     : CFG_DATA_W'($urandom()));
      endcase
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        send_random_buffer(count);
        sent += count;
      end
      wait_idle();
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = REG_ENABLE;
    cfg_data              = '0;
    frame_ch.valid        = 1'b0;
    frame_ch.left_sample  = '0;
    frame_ch.right_sample = '0;
    frame_ch.adc_index    = '0;
    frame_ch.last_frame   = 1'b0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_enable_gating();
    test_directed_extremes();
    test_long_buffers();
    test_random_buffers();
    wait_idle();

    $display("covered %0d accepted frames with %0d register writes over eight traffic phases",
             frames_sent, reg_writes);
    $display("checked %0d glitch beats, %0d mismatches", glitches_seen, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
